>>> rtl/core/psq_pkg.sv
package psq_pkg;

    // Pixel word width (Q16.16) and derived result width
    localparam int DATA_WIDTH = 32;
    localparam int OUT_WIDTH  = DATA_WIDTH + 1;
    localparam int DQ_WIDTH   = 16;

    // One input beat: a pixel of each image triplet
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] sci_a;
        logic signed [DATA_WIDTH-1:0] sci_b;
        logic        [DATA_WIDTH-1:0] err_a;
        logic        [DATA_WIDTH-1:0] err_b;
        logic        [DQ_WIDTH-1:0]   dq_a;
        logic        [DQ_WIDTH-1:0]   dq_b;
    } pix_in_t;

    // One result beat
    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] sci_diff;
        logic        [OUT_WIDTH-1:0] err_comb;
        logic        [DQ_WIDTH-1:0]  dq_comb;
    } pix_out_t;

endpackage

>>> rtl/core/pixel_subtract_error_quadrature.sv
// Throughput: one beat per cycle; a stall at the output holds every stage.
// Stages: split squares, square assembly, sum of squares, then one stage per
// root bit of the restoring square root (DATA_WIDTH + 1 stages).
// Reset clears the stage valid bits only; the data registers are not reset.
module pixel_subtract_error_quadrature
    import psq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     src_valid,
    output logic     src_stall,
    input  pix_in_t  src_data,
    output logic     dst_valid,
    input  logic     dst_stall,
    output pix_out_t dst_data
);

    localparam int LO_W  = DATA_WIDTH / 2;
    localparam int HI_W  = DATA_WIDTH - LO_W;
    localparam int SQ_W  = 2 * DATA_WIDTH;
    localparam int SUM_W = SQ_W + 1;
    localparam int RAD_W = 2 * OUT_WIDTH;
    localparam int REM_W = DATA_WIDTH + 2;
    localparam int CUR_W = REM_W + 2;
    localparam int NS    = OUT_WIDTH;

    logic adv;

    // Stage 1: difference, flag OR, split partial products
    logic                        s1_valid_reg;
    logic signed [OUT_WIDTH-1:0] s1_diff_reg;
    logic        [DQ_WIDTH-1:0]  s1_dq_reg;
    logic        [2*LO_W-1:0]    s1_a_ll_reg, s1_b_ll_reg;
    logic        [DATA_WIDTH-1:0] s1_a_hl_reg, s1_b_hl_reg;
    logic        [2*HI_W-1:0]    s1_a_hh_reg, s1_b_hh_reg;

    logic signed [OUT_WIDTH-1:0] s1_diff_next;
    logic        [2*LO_W-1:0]    s1_a_ll_next, s1_b_ll_next;
    logic        [DATA_WIDTH-1:0] s1_a_hl_next, s1_b_hl_next;
    logic        [2*HI_W-1:0]    s1_a_hh_next, s1_b_hh_next;
    logic        [LO_W-1:0]      a_lo, b_lo;
    logic        [HI_W-1:0]      a_hi, b_hi;

    // Stage 2: full squares
    logic                        s2_valid_reg;
    logic signed [OUT_WIDTH-1:0] s2_diff_reg;
    logic        [DQ_WIDTH-1:0]  s2_dq_reg;
    logic        [SQ_W-1:0]      s2_sq_a_reg, s2_sq_b_reg;
    logic        [SQ_W-1:0]      s2_sq_a_next, s2_sq_b_next;

    // Stage 3: sum of squares
    logic                        s3_valid_reg;
    logic signed [OUT_WIDTH-1:0] s3_diff_reg;
    logic        [DQ_WIDTH-1:0]  s3_dq_reg;
    logic        [SUM_W-1:0]     s3_sum_reg;

    // Root stages: one root bit per stage
    logic        [NS-1:0]        rt_valid_reg;
    logic signed [OUT_WIDTH-1:0] rt_diff_reg [NS];
    logic        [DQ_WIDTH-1:0]  rt_dq_reg   [NS];
    logic        [OUT_WIDTH-1:0] rt_root_reg [NS];
    logic        [REM_W-1:0]     rt_rem_reg  [NS-1];
    logic        [RAD_W-1:0]     rt_rad_reg  [NS-1];

    logic        [OUT_WIDTH-1:0] rt_root_next [NS];
    logic        [REM_W-1:0]     rt_rem_next  [NS];
    logic        [RAD_W-1:0]     rt_rad_next  [NS];

    // Advance the whole pipe unless the output beat is held
    assign adv       = !(dst_valid && dst_stall);
    assign src_stall = !adv;

    // Split each error word into halves for narrow multipliers
    always_comb
    begin
        a_lo = src_data.err_a[LO_W-1:0];
        a_hi = src_data.err_a[DATA_WIDTH-1:LO_W];
        b_lo = src_data.err_b[LO_W-1:0];
        b_hi = src_data.err_b[DATA_WIDTH-1:LO_W];
        s1_a_ll_next = (2*LO_W)'(a_lo) * (2*LO_W)'(a_lo);
        s1_b_ll_next = (2*LO_W)'(b_lo) * (2*LO_W)'(b_lo);
        s1_a_hl_next = DATA_WIDTH'(a_hi) * DATA_WIDTH'(a_lo);
        s1_b_hl_next = DATA_WIDTH'(b_hi) * DATA_WIDTH'(b_lo);
        s1_a_hh_next = (2*HI_W)'(a_hi) * (2*HI_W)'(a_hi);
        s1_b_hh_next = (2*HI_W)'(b_hi) * (2*HI_W)'(b_hi);
        s1_diff_next = {src_data.sci_a[DATA_WIDTH-1], src_data.sci_a}
                     - {src_data.sci_b[DATA_WIDTH-1], src_data.sci_b};
    end

    // Assemble squares from the partial products
    always_comb
    begin
        s2_sq_a_next = (SQ_W'(s1_a_hh_reg) << (2*LO_W))
                     + (SQ_W'(s1_a_hl_reg) << (LO_W+1))
                     + SQ_W'(s1_a_ll_reg);
        s2_sq_b_next = (SQ_W'(s1_b_hh_reg) << (2*LO_W))
                     + (SQ_W'(s1_b_hl_reg) << (LO_W+1))
                     + SQ_W'(s1_b_ll_reg);
    end

    // Restoring square root, one bit per stage
    for (genvar k = 0; k < NS; k++)
    begin : g_root
        logic [REM_W-1:0]     rem_in;
        logic [OUT_WIDTH-1:0] root_in;
        logic [RAD_W-1:0]     rad_in;
        logic [CUR_W-1:0]     cur;
        logic [CUR_W-1:0]     trial;
        logic                 take;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = RAD_W'(s3_sum_reg);
        end
        else
        begin : g_next
            assign rem_in  = rt_rem_reg[k-1];
            assign root_in = rt_root_reg[k-1];
            assign rad_in  = rt_rad_reg[k-1];
        end

        assign cur   = {rem_in, rad_in[RAD_W-1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign take  = (cur >= trial);

        assign rt_rem_next[k]  = take ? REM_W'(cur - trial) : cur[REM_W-1:0];
        assign rt_root_next[k] = {root_in[OUT_WIDTH-2:0], take};
        assign rt_rad_next[k]  = {rad_in[RAD_W-3:0], 2'b00};
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            rt_valid_reg <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg <= src_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            rt_valid_reg <= {rt_valid_reg[NS-2:0], s3_valid_reg};
        end
    end

    // Advance the data registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_diff_reg  <= s1_diff_next;
            s1_dq_reg    <= src_data.dq_a | src_data.dq_b;
            s1_a_ll_reg  <= s1_a_ll_next;
            s1_b_ll_reg  <= s1_b_ll_next;
            s1_a_hl_reg  <= s1_a_hl_next;
            s1_b_hl_reg  <= s1_b_hl_next;
            s1_a_hh_reg  <= s1_a_hh_next;
            s1_b_hh_reg  <= s1_b_hh_next;

            s2_diff_reg  <= s1_diff_reg;
            s2_dq_reg    <= s1_dq_reg;
            s2_sq_a_reg  <= s2_sq_a_next;
            s2_sq_b_reg  <= s2_sq_b_next;

            s3_diff_reg  <= s2_diff_reg;
            s3_dq_reg    <= s2_dq_reg;
            s3_sum_reg   <= SUM_W'(s2_sq_a_reg) + SUM_W'(s2_sq_b_reg);

            rt_diff_reg[0] <= s3_diff_reg;
            rt_dq_reg[0]   <= s3_dq_reg;
            for (int i = 1; i < NS; i++)
            begin
                rt_diff_reg[i] <= rt_diff_reg[i-1];
                rt_dq_reg[i]   <= rt_dq_reg[i-1];
            end
            for (int i = 0; i < NS; i++)
            begin
                rt_root_reg[i] <= rt_root_next[i];
            end
            for (int i = 0; i < NS-1; i++)
            begin
                rt_rem_reg[i] <= rt_rem_next[i];
                rt_rad_reg[i] <= rt_rad_next[i];
            end
        end
    end

    // Drive the result beat from the last root stage
    assign dst_valid         = rt_valid_reg[NS-1];
    assign dst_data.sci_diff = rt_diff_reg[NS-1];
    assign dst_data.err_comb = rt_root_reg[NS-1];
    assign dst_data.dq_comb  = rt_dq_reg[NS-1];

    // A held result beat must back-pressure the input
    assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_stall |-> src_stall)
        else $error("held result beat did not stall input");

    // An accepted beat lands in the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && !src_stall |=> s1_valid_reg)
        else $error("accepted beat lost at first stage");

    // A stall freezes every valid bit in the pipe
    assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |=> $stable(rt_valid_reg) && $stable(s1_valid_reg)
                      && $stable(s2_valid_reg) && $stable(s3_valid_reg))
        else $error("pipe moved during stall");

    // An empty output slot lets the input through
    assert property (@(posedge clk) disable iff (!rst_n)
        !dst_valid |-> !src_stall)
        else $error("input stalled with empty output");

endmodule

>>> tb/sv/pixel_subtract_error_quadrature_tb.sv
`timescale 1ns / 100ps

module pixel_subtract_error_quadrature_tb;
    import psq_pkg::*;

    localparam int PIPE_LATENCY  = DATA_WIDTH + 4;
    localparam int RANDOM_PIXELS = 1500;
    localparam int BLOCK_PIXELS  = 50;
    localparam int CYCLE_LIMIT   = 400000;

    // One directed row: the pixel, and its result where it is typed in by hand
    typedef struct {
        pix_in_t  px;
        bit       typed;
        pix_out_t res;
    } stim_row_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     src_valid;
    logic     src_stall;
    pix_in_t  src_data;
    logic     dst_valid;
    logic     dst_stall;
    pix_out_t dst_data;

    pix_out_t  owed_pixels[$];
    stim_row_t directed_rows[$];
    bit        tx_idle;
    bit        rx_idle;
    int        stall_left;
    int        pixels_sent;
    int        pixels_checked;
    int        mismatches;
    int        cycle_count;

    always #5 clk = ~clk;

    pixel_subtract_error_quadrature DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

    // Difference, floor of the quadrature root, and OR of the flag words
    function automatic pix_out_t pixel_combine(input pix_in_t px);
        logic [2*DATA_WIDTH+1:0] energy;
        logic [2*DATA_WIDTH+1:0] trial_sq;
        logic [2*DATA_WIDTH+1:0] ea_w;
        logic [2*DATA_WIDTH+1:0] eb_w;
        logic [OUT_WIDTH-1:0]    root;
        logic [OUT_WIDTH-1:0]    trial;
        pix_out_t                r;
        r.sci_diff = {px.sci_a[DATA_WIDTH-1], px.sci_a} - {px.sci_b[DATA_WIDTH-1], px.sci_b};
        ea_w   = (2*DATA_WIDTH+2)'(px.err_a);
        eb_w   = (2*DATA_WIDTH+2)'(px.err_b);
        energy = ea_w * ea_w + eb_w * eb_w;
        root   = '0;
        // restoring root: keep each bit whose square still fits
        for (int b = OUT_WIDTH - 1; b >= 0; b--) begin
            trial    = root | (OUT_WIDTH'(1) << b);
            trial_sq = {{OUT_WIDTH{1'b0}}, trial} * {{OUT_WIDTH{1'b0}}, trial};
            if (trial_sq <= energy)
                root = trial;
        end
        r.err_comb = root;
        r.dq_comb  = px.dq_a | px.dq_b;
        return r;
    endfunction

    function automatic stim_row_t make_row(
        input logic [DATA_WIDTH-1:0] sa, input logic [DATA_WIDTH-1:0] sb,
        input logic [DATA_WIDTH-1:0] ea, input logic [DATA_WIDTH-1:0] eb,
        input logic [DQ_WIDTH-1:0] qa, input logic [DQ_WIDTH-1:0] qb,
        input bit typed, input logic [OUT_WIDTH-1:0] diff,
        input logic [OUT_WIDTH-1:0] root, input logic [DQ_WIDTH-1:0] q);
        stim_row_t row;
        row.px.sci_a    = sa;
        row.px.sci_b    = sb;
        row.px.err_a    = ea;
        row.px.err_b    = eb;
        row.px.dq_a     = qa;
        row.px.dq_b     = qb;
        row.typed       = typed;
        row.res.sci_diff = diff;
        row.res.err_comb = root;
        row.res.dq_comb  = q;
        return row;
    endfunction

    // Favor the corners of a 32-bit word, otherwise anything
    function automatic logic [DATA_WIDTH-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h0000_0001;
            5:       return $urandom_range(0, 32'h0001_0000);
            default: return $urandom;
        endcase
    endfunction

    // Random pixel; a quarter carry error pairs from a scaled Pythagorean triple
    function automatic pix_in_t random_pixel();
        pix_in_t         px;
        logic [31:0]     k;
        logic [31:0]     leg_p;
        logic [31:0]     leg_q;
        px.sci_a = pick_word();
        px.sci_b = pick_word();
        if ($urandom_range(0, 3) == 0) begin
            k = $urandom_range(1, 32'h0F0F_0F0F);
            case ($urandom_range(0, 2))
                0:       begin leg_p = 3; leg_q = 4;  end
                1:       begin leg_p = 5; leg_q = 12; end
                default: begin leg_p = 8; leg_q = 15; end
            endcase
            if ($urandom_range(0, 1) == 1) begin
                px.err_a = k * leg_p;
                px.err_b = k * leg_q;
            end
            else begin
                px.err_a = k * leg_q;
                px.err_b = k * leg_p;
            end
        end
        else begin
            px.err_a = pick_word();
            px.err_b = pick_word();
        end
        px.dq_a = DQ_WIDTH'($urandom);
        px.dq_b = ($urandom_range(0, 3) == 0) ? '0 : DQ_WIDTH'($urandom);
        return px;
    endfunction

    // Offer one beat, after a random gap when send idling is on, hold it until taken, log what it owes
    task automatic send_pixel(input pix_in_t px, input bit typed, input pix_out_t res);
        int gap;
        gap = tx_idle ? $urandom_range(0, 14) : 0;
        @(negedge clk);
        if (gap > 0) begin
            src_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= px;
        do
            @(posedge clk);
        while (src_stall);
        owed_pixels.push_back(typed ? res : pixel_combine(px));
        pixels_sent++;
    endtask

    // Drop valid and wait for every owed result to come back
    task automatic hold_until_drained();
        @(negedge clk);
        src_valid <= 1'b0;
        while (owed_pixels.size() != 0)
            @(posedge clk);
    endtask

    // Receiver stall: count down the stall drawn at the last result beat
    always @(negedge clk) begin
        if (stall_left > 0) begin
            dst_stall  <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
            dst_stall <= 1'b0;
    end

    // Compare each result beat with the oldest owed result
    always @(posedge clk) begin
        pix_out_t want;
        if (rst_n && dst_valid && !dst_stall) begin
            if (owed_pixels.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got %h", $time, dst_data);
                mismatches++;
            end
            else begin
                want = owed_pixels.pop_front();
                pixels_checked++;
                if (dst_data.sci_diff !== want.sci_diff) begin
                    $display("%0t: sci_diff expected %h, got %h",
                             $time, want.sci_diff, dst_data.sci_diff);
                    mismatches++;
                end
                if (dst_data.err_comb !== want.err_comb) begin
                    $display("%0t: err_comb expected %h, got %h",
                             $time, want.err_comb, dst_data.err_comb);
                    mismatches++;
                end
                if (dst_data.dq_comb !== want.dq_comb) begin
                    $display("%0t: dq_comb expected %h, got %h",
                             $time, want.dq_comb, dst_data.dq_comb);
                    mismatches++;
                end
            end
            stall_left = rx_idle ? $urandom_range(0, 14) : 0;
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: watchdog expired with %0d results owed", $time, owed_pixels.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        rst_n          = 1'b0;
        src_valid      = 1'b0;
        src_data       = '0;
        dst_stall      = 1'b0;
        tx_idle        = 1'b0;
        rx_idle        = 1'b0;
        stall_left     = 0;
        pixels_sent    = 0;
        pixels_checked = 0;
        mismatches     = 0;
        cycle_count    = 0;

        // sci_a, sci_b, err_a, err_b, dq_a, dq_b, typed, diff, root, dq
        directed_rows.push_back(make_row(32'h0, 32'h0, 32'h0, 32'h0, 16'h0000, 16'h0000,
                                         1'b1, 33'h0_0000_0000, 33'h0, 16'h0000));
        directed_rows.push_back(make_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0,
                                         16'hFFFF, 16'h0000,
                                         1'b1, 33'h0_FFFF_FFFF, 33'h0, 16'hFFFF));
        directed_rows.push_back(make_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0,
                                         16'h0000, 16'hFFFF,
                                         1'b1, 33'h1_0000_0001, 33'h0, 16'hFFFF));
        directed_rows.push_back(make_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0,
                                         16'hA5A5, 16'h5A5A,
                                         1'b1, 33'h0_0000_0000, 33'h0_FFFF_FFFF, 16'hFFFF));
        directed_rows.push_back(make_row(32'h8000_0000, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
                                         16'h0F0F, 16'h0F0F,
                                         1'b1, 33'h0_0000_0000, 33'h0_FFFF_FFFF, 16'h0F0F));
        directed_rows.push_back(make_row(32'hFFFF_FFFF, 32'h0000_0001, 32'h0003_0000,
                                         32'h0004_0000, 16'h0001, 16'h8000,
                                         1'b1, 33'h1_FFFF_FFFE, 33'h0_0005_0000, 16'h8001));
        directed_rows.push_back(make_row(32'h0000_0001, 32'hFFFF_FFFF, 32'h1, 32'h0,
                                         16'h00FF, 16'hFF00,
                                         1'b1, 33'h0_0000_0002, 33'h1, 16'hFFFF));
        directed_rows.push_back(make_row(32'h8000_0000, 32'h0, 32'h0, 32'h1,
                                         16'h0000, 16'h0000,
                                         1'b1, 33'h1_8000_0000, 33'h1, 16'h0000));
        directed_rows.push_back(make_row(32'h0, 32'h8000_0000, 32'h0, 32'h0,
                                         16'h1234, 16'h0000,
                                         1'b1, 33'h0_8000_0000, 33'h0, 16'h1234));
        directed_rows.push_back(make_row(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0,
                                         16'h0000, 16'h4321,
                                         1'b1, 33'h0_8000_0000, 33'h0, 16'h4321));
        // both errors at full scale: largest root
        directed_rows.push_back(make_row(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                                         32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0, '0, '0));
        directed_rows.push_back(make_row(32'h1234_5678, 32'h8765_4321, 32'h8000_0000,
                                         32'h8000_0000, 16'hAAAA, 16'h5555, 1'b0, '0, '0, '0));
        directed_rows.push_back(make_row(32'h0001_0000, 32'h0000_8000, 32'h1, 32'h1,
                                         16'h0002, 16'h0004, 1'b0, '0, '0, '0));
        directed_rows.push_back(make_row(32'hFFFF_0000, 32'h0001_0000, 32'h0000_FFFF,
                                         32'h0001_0000, 16'h8000, 16'h0001, 1'b0, '0, '0, '0));
        directed_rows.push_back(make_row(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                                         32'h5555_5555, 16'hC3C3, 16'h3C3C, 1'b0, '0, '0, '0));
        directed_rows.push_back(make_row(32'hAAAA_AAAA, 32'h5555_5555, 32'h7FFF_FFFF,
                                         32'hFFFF_FFFE, 16'h0000, 16'hFFFF, 1'b0, '0, '0, '0));

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed rows, send idling switched in on odd rows and receive idling on alternate pairs
        foreach (directed_rows[i]) begin
            tx_idle = (i % 2 == 1);
            rx_idle = (i % 4 >= 2);
            send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].res);
        end
        hold_until_drained();

        // Random pixels in blocks, each with its own idling mix
        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            if (n % BLOCK_PIXELS == 0) begin
                tx_idle = (n != 0) && ($urandom_range(0, 2) != 0);
                rx_idle = (n != 0) && ($urandom_range(0, 2) != 0);
                if ($urandom_range(0, 7) == 0)
                    hold_until_drained();
            end
            send_pixel(random_pixel(), 1'b0, '0);
        end

        // Drain, then give stray beats time to show up
        hold_until_drained();
        repeat (2 * PIPE_LATENCY) @(posedge clk);

        $display("summary: %0d pixels sent (%0d directed: full-scale sums and errors),",
                 pixels_sent, directed_rows.size());
        $display("summary: %0d results compared under random gaps and stalls, %0d mismatches",
                 pixels_checked, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/psq_pkg.sv
rtl/core/pixel_subtract_error_quadrature.sv
tb/sv/pixel_subtract_error_quadrature_tb.sv
